// File: design/bqs_pkg.sv
`default_nettype none
package bqs_pkg;
  localparam int MaxThrows = 256;
  localparam int IdxW = $clog2(MaxThrows);
  localparam int CntW = $clog2(MaxThrows + 1);
  localparam int DataW = 32;
  localparam int QDepth = 2;

  // floor(n*num/100000) as (n * ceil(num*2^26/100000)) >> 26, exact while n*100000 < 2^26
  localparam int MulShift = 26;
  localparam int MulW = 26;
  localparam logic [MulW-1:0] Tail1Mul = 26'd10646822;
  localparam logic [MulW-1:0] Tail1UpMul = 26'd56462043;
  localparam logic [MulW-1:0] Tail2Mul = 26'd1526727;
  localparam logic [MulW-1:0] Tail2UpMul = 26'd65582138;

  typedef struct packed {
    logic signed [DataW-1:0] sample_value;
    logic is_last;
  } in_beat_t;

  typedef struct packed {
    logic signed [DataW-1:0] median_value;
    logic signed [DataW-1:0] low_one_sigma;
    logic signed [DataW-1:0] high_one_sigma;
    logic signed [DataW-1:0] low_two_sigma;
    logic signed [DataW-1:0] high_two_sigma;
    logic overflowed;
  } out_beat_t;

  // command from front to back
  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic insert;
    logic emit;
    logic drop;
  } cmd_t;
endpackage
`default_nettype wire

// File: design/bqs_if.sv
`default_nettype none
interface bqs_in_if;
  import bqs_pkg::*;
  logic valid;
  logic ready;
  in_beat_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface bqs_out_if;
  import bqs_pkg::*;
  logic valid;
  logic ready;
  out_beat_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// File: design/bqs_front.sv
`default_nettype none
module bqs_front (
  input  wire logic clk,
  input  wire logic rst,
  bqs_in_if.sink in_ch,
  output bqs_pkg::cmd_t cmd,
  output logic cmd_valid,
  input  wire logic cmd_ready
);
  import bqs_pkg::*;
  logic [CntW-1:0] count;
  logic full;
  assign full = (count == CntW'(MaxThrows));
  assign in_ch.ready = cmd_ready;
  assign cmd_valid = in_ch.valid;
  always_comb begin
    cmd.value = in_ch.data.sample_value;
    cmd.insert = !full;
    cmd.drop = full;
    cmd.emit = in_ch.data.is_last;
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (in_ch.valid && cmd_ready) begin
      if (in_ch.data.is_last) count <= '0;
      else if (!full) count <= count + 1'b1;
    end
  end
endmodule
`default_nettype wire

// File: design/bqs_queue.sv
`default_nettype none
module bqs_queue (
  input  wire logic clk,
  input  wire logic rst,
  input  bqs_pkg::cmd_t wr_cmd,
  input  wire logic wr_valid,
  output logic wr_ready,
  output bqs_pkg::cmd_t rd_cmd,
  output logic rd_valid,
  input  wire logic rd_ready
);
  import bqs_pkg::*;
  cmd_t slot [QDepth];
  logic [$clog2(QDepth)-1:0] wp, rp;
  logic [$clog2(QDepth):0] fill;
  assign wr_ready = fill != ($clog2(QDepth)+1)'(QDepth);
  assign rd_valid = fill != '0;
  assign rd_cmd = slot[rp];
  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) slot[wp] <= wr_cmd;
    if (rst) begin
      wp <= '0; rp <= '0; fill <= '0;
    end else begin
      if (wr_valid && wr_ready) wp <= wp + 1'b1;
      if (rd_valid && rd_ready) rp <= rp + 1'b1;
      fill <= fill + ($clog2(QDepth)+1)'(wr_valid && wr_ready)
                   - ($clog2(QDepth)+1)'(rd_valid && rd_ready);
    end
  end
endmodule
`default_nettype wire

// File: design/bqs_back.sv
`default_nettype none
module bqs_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  wire logic clk,
  input  wire logic we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0] wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

module bqs_back (
  input  wire logic clk,
  input  wire logic rst,
  input  bqs_pkg::cmd_t cmd,
  input  wire logic cmd_valid,
  output logic cmd_ready,
  bqs_out_if.source out_ch
);
  import bqs_pkg::*;
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_PLACE = 3'd2;
  localparam logic [2:0] S_IDX   = 3'd3;
  localparam logic [2:0] S_RD    = 3'd4;
  localparam logic [2:0] S_GET   = 3'd5;

  localparam logic [2:0] ST_MED = 3'd0;
  localparam logic [2:0] ST_L1  = 3'd1;
  localparam logic [2:0] ST_H1  = 3'd2;
  localparam logic [2:0] ST_L2  = 3'd3;
  localparam logic [2:0] ST_H2  = 3'd4;

  logic [2:0] state;
  logic [CntW-1:0] count;
  logic drop_flag;
  logic signed [DataW-1:0] value;
  logic [IdxW-1:0] pos;
  logic emit;
  logic [CntW-1:0] n_r;
  logic ovf_r;
  logic [2:0] stat;
  logic [IdxW-1:0] idx;
  logic [IdxW-1:0] idx_next;
  logic [CntW-1:0] mul_n;
  logic [MulW-1:0] mul_k;
  logic [CntW+MulW-1:0] prod;
  logic ram_we;
  logic [IdxW-1:0] ram_waddr;
  logic [IdxW-1:0] ram_raddr;
  logic signed [DataW-1:0] ram_wdata;
  logic signed [DataW-1:0] ram_rdata;
  out_beat_t res;
  logic out_v;
  logic take;

  assign take = cmd_valid && cmd_ready;
  assign cmd_ready = (state == S_IDLE);
  assign out_ch.valid = out_v;
  assign out_ch.data = res;

  bqs_ram #(.Width(DataW), .Depth(MaxThrows)) u_store (
    .clk,
    .we(ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // insertion: walk down from the top, moving larger entries up one slot per cycle
  always_comb begin
    ram_we = 1'b0;
    ram_waddr = pos;
    ram_wdata = value;
    ram_raddr = idx;
    unique case (state)
      S_IDLE: ram_raddr = IdxW'(count - 1'b1);
      S_SCAN: begin
        ram_we = 1'b1;
        if (ram_rdata > value) begin
          ram_wdata = ram_rdata;
          ram_raddr = pos - IdxW'(2);
        end
      end
      S_PLACE: ram_we = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    mul_n = n_r;
    mul_k = '0;
    unique case (stat)
      ST_L1: mul_k = Tail1Mul;
      ST_H1: mul_k = Tail1UpMul;
      ST_L2: mul_k = Tail2Mul;
      ST_H2: begin
        mul_n = n_r - 1'b1;
        mul_k = Tail2UpMul;
      end
      default: ;
    endcase
    prod = mul_n * mul_k;
    idx_next = (stat == ST_MED) ? IdxW'(n_r >> 1) : prod[MulShift +: IdxW];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; count <= '0; drop_flag <= 1'b0; out_v <= 1'b0;
      pos <= '0; value <= '0; emit <= 1'b0; n_r <= '0; ovf_r <= 1'b0;
      stat <= ST_MED; idx <= '0; res <= '0;
    end else begin
      if (out_v && out_ch.ready) out_v <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (take) begin
            value <= cmd.value;
            pos <= IdxW'(count);
            emit <= cmd.emit;
            stat <= ST_MED;
            if (cmd.emit) begin
              n_r <= count + CntW'(cmd.insert);
              ovf_r <= drop_flag | cmd.drop;
              count <= '0;
              drop_flag <= 1'b0;
            end else begin
              count <= count + CntW'(cmd.insert);
              drop_flag <= drop_flag | cmd.drop;
            end
            if (cmd.insert) state <= (count == '0) ? S_PLACE : S_SCAN;
            else if (cmd.emit) state <= S_IDX;
          end
        end
        S_SCAN: begin
          if (ram_rdata > value) begin
            pos <= pos - 1'b1;
            if (pos == IdxW'(1)) state <= S_PLACE;
          end else begin
            state <= emit ? S_IDX : S_IDLE;
          end
        end
        S_PLACE: begin
          state <= emit ? S_IDX : S_IDLE;
        end
        // readout starts only once the previous result has left
        S_IDX: begin
          if (!out_v) begin
            idx <= idx_next;
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_GET;
        end
        S_GET: begin
          case (stat)
            ST_MED: res.median_value <= ram_rdata;
            ST_L1: res.low_one_sigma <= ram_rdata;
            ST_H1: res.high_one_sigma <= ram_rdata;
            ST_L2: res.low_two_sigma <= ram_rdata;
            default: res.high_two_sigma <= ram_rdata;
          endcase
          if (stat == ST_H2) begin
            res.overflowed <= ovf_r;
            out_v <= 1'b1;
            state <= S_IDLE;
          end else begin
            stat <= stat + 1'b1;
            state <= S_IDX;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: design/bin_quantile_selector_unit.sv
// bin_quantile_selector_unit: order statistics of one bin's throws.
// in_ch carries one throw per beat (sample_value, is_last); out_ch carries
// one result beat per bin: median, one and two sigma quantiles, overflowed.
// The front marks each throw as insert, or drop once MaxThrows are held,
// and passes it through a two-entry queue to the back, which keeps the
// values ascending in a RAM by insertion, one shifted entry per cycle.
// An inserted throw occupies the back until each held value larger than it
// has moved up a slot; the back takes no new throw until it is done, and a
// dropped throw leaves the back idle. A last throw then adds a readout. Its
// result follows its acceptance through the queue, the insert, then five
// passes of index, read and capture.
// A stalled receiver holds the result; the back keeps sorting the next bin
// and waits before its readout, and in_ch stalls once the queue fills.
// Reset (rst, synchronous) empties the queue and clears count and drop flag.
`default_nettype none
module bin_quantile_selector_unit (
  input wire logic clk,
  input wire logic rst,
  bqs_in_if.sink in_ch,
  bqs_out_if.source out_ch
);
  import bqs_pkg::*;
  cmd_t f_cmd, b_cmd;
  logic f_v, f_r, b_v, b_r;
  bqs_front u_front(.clk, .rst, .in_ch, .cmd(f_cmd), .cmd_valid(f_v), .cmd_ready(f_r));
  bqs_queue u_queue(.clk, .rst, .wr_cmd(f_cmd), .wr_valid(f_v), .wr_ready(f_r),
                    .rd_cmd(b_cmd), .rd_valid(b_v), .rd_ready(b_r));
  bqs_back u_back(.clk, .rst, .cmd(b_cmd), .cmd_valid(b_v), .cmd_ready(b_r), .out_ch);
endmodule
`default_nettype wire

// File: design/bqs_checker.sv
`default_nettype none
module bqs_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic in_ready
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_rst_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");
  a_no_b2b: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |=> !out_valid) else $error("result repeated");
  a_rst_ready: assert property (@(posedge clk) rst |=> in_ready)
    else $error("input blocked after reset");
endmodule
bind bin_quantile_selector_unit bqs_checker u_chk(.clk(clk), .rst(rst),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .in_ready(in_ch.ready));
`default_nettype wire
